// ----- rtl/modexp_pkg.sv -----
package modexp_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOAD_BASE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_FINISH
    } t_state;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;          // capture a new word and initialise
        logic red_step;      // one shift-subtract step of the base reduction
        logic mul_acc_start; // set up product acc * base
        logic sq_start;      // set up product base * base
        logic mul_step;      // one add-and-double step of the product
        logic acc_wr;        // take the product into the accumulator
        logic base_wr;       // take the product (or remainder) into the base
        logic exp_shift;     // move to the next exponent bit
        logic out_wr;        // load the result register
    } t_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic exp_zero;      // no exponent bits left to scan
        logic exp_lsb;       // current exponent bit
        logic pb_zero;       // product multiplier exhausted
    } t_sts;

endpackage

// ----- rtl/modexp_ctrl.sv -----
module modexp_ctrl
    import modexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CW = $clog2(WIDTH);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_REDUCE;
            end
            ST_REDUCE: begin
                if (r_cnt == '0) n_state = ST_LOAD_BASE;
            end
            ST_LOAD_BASE: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (i_sts.exp_zero) n_state = ST_FINISH;
                else if (i_sts.exp_lsb)      n_state = ST_MUL_ACC;
                else                         n_state = ST_MUL_SQ;
            end
            ST_MUL_ACC: begin
                if (i_sts.pb_zero) n_state = ST_MUL_SQ;
            end
            ST_MUL_SQ: begin
                if (i_sts.pb_zero) n_state = ST_CHECK;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
            end
            ST_LOAD_BASE: begin
                o_cmd.base_wr = 1'b1;
            end
            ST_CHECK: begin
                priority if (i_sts.exp_zero) begin
                end else if (i_sts.exp_lsb) begin
                    o_cmd.mul_acc_start = 1'b1;
                end else begin
                    o_cmd.sq_start = 1'b1;
                end
            end
            ST_MUL_ACC: begin
                if (i_sts.pb_zero) begin
                    o_cmd.acc_wr   = 1'b1;
                    o_cmd.sq_start = 1'b1;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            ST_MUL_SQ: begin
                if (i_sts.pb_zero) begin
                    o_cmd.base_wr   = 1'b1;
                    o_cmd.exp_shift = 1'b1;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.out_wr = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    // Reduction step counter
    always_comb begin
        n_cnt = r_cnt;
        if (w_accept) begin
            n_cnt = CW'(WIDTH - 1);
        end else if (r_state == ST_REDUCE) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Result word held until taken
    assign n_out_valid = o_cmd.out_wr || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/modexp_dp.sv -----
module modexp_dp
    import modexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic [31:0] i_cfg_modulus,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_exponent,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [31:0] o_power_result
);

    localparam int OW = (WIDTH < 32) ? WIDTH : 32;

    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_base;
    logic [OW-1:0]    r_exp;
    logic [WIDTH-1:0] r_pa;
    logic [WIDTH-1:0] r_pb;
    logic [WIDTH-1:0] r_pacc;
    logic [31:0]      r_out;

    logic [WIDTH:0]   w_mod_ext;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_sum_red;
    logic [WIDTH:0]   w_dbl;
    logic [WIDTH:0]   w_dbl_red;
    logic [WIDTH:0]   w_shl;
    logic [WIDTH:0]   w_shl_red;
    logic             w_mod_zero;
    logic             w_mod_le1;

    assign w_mod_ext  = {1'b0, r_mod};
    assign w_mod_zero = (r_mod == '0);
    assign w_mod_le1  = (r_mod[WIDTH-1:1] == '0);

    // Add, double and shift-in, each followed by one conditional subtraction
    always_comb begin
        w_sum     = {1'b0, r_pacc} + {1'b0, r_pa};
        w_sum_red = (w_sum >= w_mod_ext) ? (w_sum - w_mod_ext) : w_sum;
        w_dbl     = {r_pa, 1'b0};
        w_dbl_red = (w_dbl >= w_mod_ext) ? (w_dbl - w_mod_ext) : w_dbl;
        w_shl     = {r_pacc, r_pb[WIDTH-1]};
        w_shl_red = (w_shl >= w_mod_ext) ? (w_shl - w_mod_ext) : w_shl;
    end

    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];
    assign o_sts.pb_zero  = (r_pb == '0);

    assign o_power_result = r_out;

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WIDTH'(1);
        end else if (i_cfg_wr) begin
            r_mod <= WIDTH'(i_cfg_modulus[OW-1:0]);
        end
    end

    // Product / reduction working registers
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load) begin
            r_pb   <= WIDTH'(i_base_value[OW-1:0]);
            r_pacc <= '0;
        end else if (i_cmd.red_step) begin
            r_pacc <= w_shl_red[WIDTH-1:0];
            r_pb   <= {r_pb[WIDTH-2:0], 1'b0};
        end else if (i_cmd.mul_acc_start) begin
            r_pa   <= r_acc;
            r_pb   <= r_base;
            r_pacc <= '0;
        end else if (i_cmd.sq_start) begin
            r_pa   <= r_base;
            r_pb   <= r_base;
            r_pacc <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_pb[0]) r_pacc <= w_sum_red[WIDTH-1:0];
            r_pa <= w_dbl_red[WIDTH-1:0];
            r_pb <= {1'b0, r_pb[WIDTH-1:1]};
        end
    end

    // Accumulator, base, exponent and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= w_mod_le1 ? '0 : WIDTH'(1);
        end else if (i_cmd.acc_wr) begin
            r_acc <= r_pacc;
        end

        if (i_cmd.base_wr) r_base <= r_pacc;

        // A zero modulus gives zero: scan no exponent bits at all
        if (i_cmd.load) begin
            r_exp <= w_mod_zero ? '0 : i_exponent[OW-1:0];
        end else if (i_cmd.exp_shift) begin
            r_exp <= {1'b0, r_exp[OW-1:1]};
        end

        if (i_cmd.out_wr) r_out <= 32'(r_acc);
    end

endmodule

// ----- rtl/modular_exponentiation_top.sv -----
// Modular exponentiation, power_result = base_value ^ exponent mod modulus, by
// right-to-left square-and-multiply. Write the modulus on the configuration port
// while the block is idle (reset value 1; a zero modulus gives 0). Each word first
// has its base reduced by shift-subtract steps; then, for every exponent bit up
// to the highest set one, come a square and, where the bit is set, a multiply,
// each running one add-and-double step per cycle until the multiplier runs out.
// Short exponents such as 65537 finish far sooner. The single shared
// add-and-double unit serves both the square and the multiply. One word is
// worked on at a time; a finished result waits in an output register while the
// next word is taken.
module modular_exponentiation_top
    import modexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_modulus,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_exponent,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_power_result
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    modexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    modexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_modulus  (i_cfg_modulus),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_power_result (o_power_result)
    );

endmodule
